// ----- design/console_line_ring_writer_defines.svh -----
// ----------------------------------------------------------------------------
// Console line ring writer: assertion macros
// Shared property shapes for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef CONSOLE_LINE_RING_WRITER_DEFINES_SVH
`define CONSOLE_LINE_RING_WRITER_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define CLRW_ASSERT_NOW(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("console line ring writer: same-cycle check failed");

// Next-cycle implication, checked outside reset
`define CLRW_ASSERT_NEXT(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("console line ring writer: next-cycle check failed");

`endif

// ----- design/clrw_pkg.sv -----
// ----------------------------------------------------------------------------
// clrw_pkg
// Types and constants shared by the console line ring writer modules.
// ----------------------------------------------------------------------------
package clrw_pkg;

	// Ring size default
	localparam int RING_LINES_DEF = 256;

	// Byte codes
	localparam logic [7:0] CHAR_TAB     = 8'h09;
	localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
	localparam logic [7:0] CHAR_RETURN  = 8'h0D;
	localparam logic [7:0] CHAR_SPACE   = 8'h20;
	localparam logic [7:0] CHAR_TILDE   = 8'h7E;

	// Line stride register
	localparam int         APB_ADDR_W        = 3;
	localparam int         APB_DATA_W        = 32;
	localparam logic [2:0] ADDR_LINE_STRIDE  = 3'd0;
	localparam logic [7:0] STRIDE_RESET      = 8'd100;
	localparam logic [7:0] STRIDE_MIN        = 8'd8;

	// Tab expansion: stop at a multiple of eight or once this many results are out
	localparam logic [7:0] TAB_MASK        = 8'h07;
	localparam logic [4:0] TAB_RESULT_STOP = 5'd15;

	// Slot numbers are widened to this before the low byte is reported
	localparam int SLOT_EXT_W = 16;

	// Command queue between front and back
	localparam int QUEUE_DEPTH = 2;

	typedef enum logic [1:0] {
		OP_NEWLINE,
		OP_RETURN,
		OP_TAB,
		OP_PRINT
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [7:0] ch;
	} cmd_t;

endpackage

// ----- design/clrw_front.sv -----
// ----------------------------------------------------------------------------
// clrw_front
// Classifies incoming bytes into commands and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module clrw_front
	import clrw_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  logic [7:0] text_byte,
	output logic       full,
	output logic       cmd_valid,
	output cmd_t       cmd,
	input  logic       cmd_take
);

	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int PTR_W = $clog2(QUEUE_DEPTH);

	cmd_t             mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	cmd_t             cls;
	logic             keep;
	logic             wr_en;
	logic             rd_en;

	// Classify the byte; drop anything that is neither control nor printable
	always_comb begin
		cls.op = OP_PRINT;
		cls.ch = text_byte;
		keep   = 1'b1;
		unique case (text_byte) inside
			CHAR_NEWLINE: cls.op = OP_NEWLINE;
			CHAR_RETURN:  cls.op = OP_RETURN;
			CHAR_TAB:     cls.op = OP_TAB;
			[CHAR_SPACE:CHAR_TILDE]: cls.op = OP_PRINT;
			default:      keep = 1'b0;
		endcase
	end

	assign full      = (count_q == CNT_W'(QUEUE_DEPTH));
	assign cmd_valid = (count_q != '0);
	assign cmd       = mem_q[rd_ptr_q];
	assign wr_en     = push && !full && keep;
	assign rd_en     = cmd_take && cmd_valid;

	// Store the classified item
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= cls;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ----- design/clrw_back.sv -----
// ----------------------------------------------------------------------------
// clrw_back
// Carries out commands one result per cycle unless pop stalls it, keeping the
// write column and ring head, and holds each result in a register until taken.
// ----------------------------------------------------------------------------
module clrw_back
	import clrw_pkg::*;
#(
	parameter int RING_LINES = RING_LINES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cmd_valid,
	input  cmd_t       cmd,
	output logic       cmd_take,
	input  logic [7:0] line_stride,
	output logic       empty,
	input  logic       pop,
	output logic [7:0] line_index,
	output logic       writes_cell,
	output logic [7:0] cell_column,
	output logic [7:0] character,
	output logic [7:0] line_length,
	output logic       last
);

	localparam int HEAD_W = (RING_LINES > 1) ? $clog2(RING_LINES) : 1;

	logic [HEAD_W-1:0] head_q;
	logic [7:0]        col_q;
	logic [4:0]        cnt_q;
	logic              out_valid_q;

	logic [HEAD_W-1:0] head_next;
	logic [HEAD_W-1:0] head_prev;
	logic [7:0]        stride_eff;
	logic              need_break;
	logic              adv;
	logic [7:0]        col_inc;
	logic [4:0]        cnt_inc;

	logic [HEAD_W-1:0] n_head;
	logic [7:0]        n_col;
	logic [4:0]        n_cnt;
	logic              done;
	logic [HEAD_W-1:0] r_slot;
	logic              r_wr;
	logic [7:0]        r_col;
	logic [7:0]        r_ch;
	logic [7:0]        r_len;
	logic              r_last;

	logic [SLOT_EXT_W-1:0] slot_ext;
	logic [HEAD_W-1:0]     slot_q;

	assign head_next  = (head_q == HEAD_W'(RING_LINES - 1)) ? '0 : head_q + 1'b1;
	assign head_prev  = (head_q == '0) ? HEAD_W'(RING_LINES - 1) : head_q - 1'b1;
	assign stride_eff = (line_stride < STRIDE_MIN) ? STRIDE_MIN : line_stride;
	assign need_break = (col_q >= stride_eff);
	assign col_inc    = col_q + 8'd1;
	assign cnt_inc    = cnt_q + 5'd1;
	assign adv        = cmd_valid && (!out_valid_q || pop);
	assign cmd_take   = adv && done;

	// Work out the next result and the state it leaves
	always_comb begin
		n_head = head_q;
		n_col  = col_q;
		n_cnt  = cnt_q;
		done   = 1'b1;
		r_slot = head_q;
		r_wr   = 1'b0;
		r_col  = '0;
		r_ch   = '0;
		r_len  = '0;
		r_last = 1'b1;
		unique case (cmd.op)
			OP_NEWLINE: begin
				n_head = head_next;
				n_col  = '0;
			end
			OP_RETURN: begin
				r_slot = head_prev;
				n_col  = '0;
			end
			OP_TAB, OP_PRINT: begin
				if (need_break) begin
					// wrap break, a cell write follows
					n_head = head_next;
					n_col  = '0;
					n_cnt  = cnt_inc;
					done   = 1'b0;
					r_last = 1'b0;
				end else begin
					r_slot = head_prev;
					r_wr   = 1'b1;
					r_col  = col_q;
					r_ch   = (cmd.op == OP_TAB) ? CHAR_SPACE : cmd.ch;
					r_len  = col_inc;
					n_col  = col_inc;
					done   = (cmd.op == OP_PRINT) || ((col_inc & TAB_MASK) == '0)
						|| (cnt_inc >= TAB_RESULT_STOP);
					n_cnt  = done ? '0 : cnt_inc;
					r_last = done;
				end
			end
			default: begin
				done = 1'b1;
			end
		endcase
	end

	// Update column, head and per-item count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			col_q       <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				head_q <= n_head;
				col_q  <= n_col;
				cnt_q  <= n_cnt;
			end
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Hold the result payload
	always_ff @(posedge clk) begin
		if (adv) begin
			slot_q      <= r_slot;
			writes_cell <= r_wr;
			cell_column <= r_col;
			character   <= r_ch;
			line_length <= r_len;
			last        <= r_last;
		end
	end

	assign slot_ext   = SLOT_EXT_W'(slot_q);
	assign line_index = slot_ext[7:0];
	assign empty      = !out_valid_q;

endmodule

// ----- design/console_line_ring_writer.sv -----
// ----------------------------------------------------------------------------
// console_line_ring_writer
// Turns a console byte stream into line updates on a ring of stored lines.
//
//   channel   direction  handshake          payload
//   input     in         push / full        text_byte
//   result    out        pop / empty        line_index, writes_cell,
//                                           cell_column, character,
//                                           line_length, last
//   config    in         psel/penable/...   line_stride at byte address 0
//
// The back sequencer issues one result per cycle while the result register
// is free or popped. Printable bytes, newline and carriage return give one
// result each, printable bytes two when a wrap break comes first; a tab gives
// up to fifteen results, breaks included. Other bytes are dropped. Reset is
// asynchronous. full rises while the two-entry command queue holds two items;
// a stalled pop holds the result register and, behind it, the sequencer.
// ----------------------------------------------------------------------------
module console_line_ring_writer
	import clrw_pkg::*;
#(
	parameter int RING_LINES = RING_LINES_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	output logic                  full,
	input  logic [7:0]            text_byte,
	output logic                  empty,
	input  logic                  pop,
	output logic [7:0]            line_index,
	output logic                  writes_cell,
	output logic [7:0]            cell_column,
	output logic [7:0]            character,
	output logic [7:0]            line_length,
	output logic                  last,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready
);

	logic [7:0] stride_q;
	logic       cmd_valid;
	logic       cmd_take;
	cmd_t       cmd;

	// Line stride register
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stride_q <= STRIDE_RESET;
		end else if (psel && penable && pwrite && pready && (paddr == ADDR_LINE_STRIDE)) begin
			stride_q <= pwdata[7:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr == ADDR_LINE_STRIDE) begin
			prdata = APB_DATA_W'(stride_q);
		end
	end

	clrw_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.text_byte (text_byte),
		.full      (full),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_take  (cmd_take)
	);

	clrw_back #(
		.RING_LINES (RING_LINES)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_valid   (cmd_valid),
		.cmd         (cmd),
		.cmd_take    (cmd_take),
		.line_stride (stride_q),
		.empty       (empty),
		.pop         (pop),
		.line_index  (line_index),
		.writes_cell (writes_cell),
		.cell_column (cell_column),
		.character   (character),
		.line_length (line_length),
		.last        (last)
	);

endmodule

// ----- design/clrw_checker.sv -----
// ----------------------------------------------------------------------------
// clrw_checker
// Port-level checks on the results of the console line ring writer.
// ----------------------------------------------------------------------------
`include "console_line_ring_writer_defines.svh"

module clrw_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       empty,
	input logic       pop,
	input logic [7:0] line_index,
	input logic       writes_cell,
	input logic [7:0] cell_column,
	input logic [7:0] character,
	input logic [7:0] line_length,
	input logic       last
);

	// A waiting result stays put until taken
	`CLRW_ASSERT_NEXT(a_hold, clk, arst_n, !empty && !pop, !empty && $stable(line_index) && $stable(last))

	// A cell write reports the length just past its column
	`CLRW_ASSERT_NOW(a_len, clk, arst_n, !empty && writes_cell, line_length == 8'(cell_column + 8'd1))

	// Length-only updates clear the line
	`CLRW_ASSERT_NOW(a_clear, clk, arst_n, !empty && !writes_cell, cell_column == 8'd0 && character == 8'd0 && line_length == 8'd0)

	// Only printable characters reach the cells
	`CLRW_ASSERT_NOW(a_print, clk, arst_n, !empty && writes_cell, character >= 8'h20 && character <= 8'h7E)

endmodule

bind console_line_ring_writer clrw_checker u_clrw_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.empty       (empty),
	.pop         (pop),
	.line_index  (line_index),
	.writes_cell (writes_cell),
	.cell_column (cell_column),
	.character   (character),
	.line_length (line_length),
	.last        (last)
);

// ----- verif/tb_console_line_ring_writer.sv -----
// ----------------------------------------------------------------------------
// tb_console_line_ring_writer
// Self-checking bench for the console line ring writer. Console bytes go in
// through the push/full side. Line updates are popped and compared in order
// with a prediction of the ring head, the write column and the line stride.
// The stride is changed over the APB port between phases and read back.
// ----------------------------------------------------------------------------
module tb_console_line_ring_writer;
	import clrw_pkg::*;

	localparam int IDLE_LIMIT = 2000;
	localparam int LONG_HOLD  = 200;
	localparam int SETTLE     = 30;
	localparam int PHASES     = 7;

	// Opening bytes: field extremes, dropped codes, tabs at odd and even columns
	localparam logic [7:0] OPENING_BYTES [21] = '{
		8'h41, CHAR_SPACE, CHAR_TILDE, 8'h7F, 8'h1F, 8'h00, 8'hFF, 8'h80,
		CHAR_TAB, CHAR_TAB, 8'h55, 8'h2A, CHAR_RETURN, 8'h61, CHAR_NEWLINE,
		CHAR_NEWLINE, CHAR_RETURN, CHAR_TAB, 8'h3F, 8'h5F, CHAR_TAB
	};

	// Stride per phase: min, below min, max, below min, random, default, min + 1
	localparam logic [7:0] PHASE_STRIDES [PHASES] = '{
		8'd8, 8'd0, 8'd255, 8'd7, 8'd40, 8'd100, 8'd9
	};

	typedef struct packed {
		logic [7:0] line_index;
		logic       writes_cell;
		logic [7:0] cell_column;
		logic [7:0] character;
		logic [7:0] line_length;
		logic       last;
	} line_update_t;

	// Predicts the line updates of each accepted byte and checks popped ones
	class line_update_predictor;
		line_update_t pending_updates[$];
		logic [7:0]   stride;
		logic [7:0]   column;
		int           head;
		int           burst;
		int           errors;
		int           checked;

		function new();
			stride  = STRIDE_RESET;
			column  = '0;
			head    = 0;
			burst   = 0;
			errors  = 0;
			checked = 0;
		endfunction

		function void emit_update(int slot, logic wr, logic [7:0] col, logic [7:0] ch,
				logic [7:0] len);
			line_update_t u;
			u.line_index  = slot[7:0];
			u.writes_cell = wr;
			u.cell_column = col;
			u.character   = ch;
			u.line_length = len;
			u.last        = 1'b0;
			pending_updates.push_back(u);
			burst++;
		endfunction

		function int prev_slot();
			return (head + RING_LINES_DEF - 1) % RING_LINES_DEF;
		endfunction

		// Close the line: the head slot becomes empty and the head advances
		function void break_line();
			column = '0;
			emit_update(head, 1'b0, '0, '0, '0);
			head = (head + 1) % RING_LINES_DEF;
		endfunction

		// Store one cell, breaking first once the column has reached the stride
		function void put_char(logic [7:0] ch);
			logic [7:0] limit;
			limit = (stride < STRIDE_MIN) ? STRIDE_MIN : stride;
			if (column >= limit)
				break_line();
			emit_update(prev_slot(), 1'b1, column, ch, column + 8'd1);
			column = column + 8'd1;
		endfunction

		function void accept_byte(logic [7:0] b);
			line_update_t u;
			burst = 0;
			if (b == CHAR_NEWLINE) begin
				break_line();
			end else if (b == CHAR_RETURN) begin
				column = '0;
				emit_update(prev_slot(), 1'b0, '0, '0, '0);
			end else if (b == CHAR_TAB) begin
				do
					put_char(CHAR_SPACE);
				while ((column & TAB_MASK) != 0 && burst < TAB_RESULT_STOP);
			end else if (b >= CHAR_SPACE && b <= CHAR_TILDE) begin
				put_char(b);
			end
			// Mark the final update of this byte
			if (burst > 0) begin
				u = pending_updates.pop_back();
				u.last = 1'b1;
				pending_updates.push_back(u);
			end
		endfunction

		function void check_field(string name, logic [7:0] want, logic [7:0] got);
			if (got !== want) begin
				errors++;
				if (errors <= 40)
					$display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, got);
			end
		endfunction

		function void compare_update(line_update_t got);
			line_update_t want;
			if (pending_updates.size() == 0) begin
				errors++;
				if (errors <= 40)
					$display("%0t: line update with none expected: expected nothing, got %h",
						$time, got);
				return;
			end
			want = pending_updates.pop_front();
			checked++;
			check_field("line_index", want.line_index, got.line_index);
			check_field("writes_cell", want.writes_cell, got.writes_cell);
			check_field("cell_column", want.cell_column, got.cell_column);
			check_field("character", want.character, got.character);
			check_field("line_length", want.line_length, got.line_length);
			check_field("last", want.last, got.last);
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n    = 1'b0;
	logic                  push      = 1'b0;
	logic                  full;
	logic [7:0]            text_byte = '0;
	logic                  empty;
	logic                  pop       = 1'b0;
	logic [7:0]            line_index;
	logic                  writes_cell;
	logic [7:0]            cell_column;
	logic [7:0]            character;
	logic [7:0]            line_length;
	logic                  last;
	logic                  psel      = 1'b0;
	logic                  penable   = 1'b0;
	logic                  pwrite    = 1'b0;
	logic [APB_ADDR_W-1:0] paddr     = '0;
	logic [APB_DATA_W-1:0] pwdata    = '0;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	line_update_predictor sb = new();
	bit quiet        = 1'b0;
	bit hold_request = 1'b0;
	int bytes_sent   = 0;

	console_line_ring_writer dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.text_byte   (text_byte),
		.empty       (empty),
		.pop         (pop),
		.line_index  (line_index),
		.writes_cell (writes_cell),
		.cell_column (cell_column),
		.character   (character),
		.line_length (line_length),
		.last        (last),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Offer one byte, with an occasional gap before it, and hold until taken
	task automatic send_byte(input logic [7:0] b);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 10)) @(negedge clk);
		end
		push      <= 1'b1;
		text_byte <= b;
		@(posedge clk);
		while (full)
			@(posedge clk);
		sb.accept_byte(b);
		bytes_sent++;
		@(negedge clk);
	endtask

	// Stop offering and let every expected update come out, then settle
	task automatic wait_idle();
		push <= 1'b0;
		while (sb.pending_updates.size() != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic apb_access(input logic wr, input logic [31:0] wdata,
			output logic [31:0] rdata);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= ADDR_LINE_STRIDE;
		pwdata  <= wdata;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		rdata = prdata;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
	endtask

	task automatic check_stride_readback(input logic [7:0] value);
		logic [31:0] readback;
		apb_access(1'b0, '0, readback);
		if (readback !== {24'd0, value}) begin
			sb.errors++;
			$display("%0t: line_stride readback mismatch: expected %0h, got %0h",
				$time, value, readback);
		end
	endtask

	task automatic set_line_stride(input logic [7:0] value);
		logic [31:0] unused;
		apb_access(1'b1, {24'd0, value}, unused);
		sb.stride = value;
		check_stride_readback(value);
	endtask

	// Mix of line control, tabs, printables and noise; long lines drop breaks
	function automatic logic [7:0] pick_byte(input bit long_lines);
		int roll;
		roll = $urandom_range(0, 99);
		if (long_lines)
			return (roll < 80) ? CHAR_TAB : 8'($urandom_range(CHAR_SPACE, CHAR_TILDE));
		if (roll < 32)
			return CHAR_NEWLINE;
		if (roll < 50)
			return CHAR_TAB;
		if (roll < 85)
			return 8'($urandom_range(CHAR_SPACE, CHAR_TILDE));
		if (roll < 90)
			return CHAR_RETURN;
		return 8'($urandom_range(0, 255));
	endfunction

	// Stimulus
	initial begin
		logic [7:0] next_stride;
		int         n_items;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		check_stride_readback(STRIDE_RESET);

		foreach (OPENING_BYTES[i])
			send_byte(OPENING_BYTES[i]);
		wait_idle();

		for (int p = 0; p < PHASES; p++) begin
			next_stride = (p == 4) ? 8'($urandom_range(8, 60)) : PHASE_STRIDES[p];
			set_line_stride(next_stride);
			// Receiver holds off while bytes keep coming, so full must rise
			if (p == 1)
				hold_request = 1'b1;
			if (p == PHASES - 1)
				quiet = 1'b1;
			n_items = (PHASE_STRIDES[p] == 8'd255) ? 45 : 25;
			repeat (n_items)
				send_byte(pick_byte(PHASE_STRIDES[p] == 8'd255));
			wait_idle();
		end

		$display("Covered %0d console bytes and %0d line updates over %0d stride settings;",
			bytes_sent, sb.checked, PHASES + 1);
		$display("the ring head finished at slot %0d.", sb.head);
		if (sb.errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	// Result side: random stalls, one long hold on request, none at the end
	initial begin
		line_update_t got;
		int           stall_left;
		stall_left = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				stall_left   = LONG_HOLD;
			end else if (stall_left == 0 && !quiet && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(1, 10);
			end
			if (stall_left > 0) begin
				stall_left--;
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
			end
			@(posedge clk);
			if (pop && !empty) begin
				got.line_index  = line_index;
				got.writes_cell = writes_cell;
				got.cell_column = cell_column;
				got.character   = character;
				got.line_length = line_length;
				got.last        = last;
				sb.compare_update(got);
			end
		end
	end

	// Watchdog: end the run when nothing has moved for too long
	initial begin
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if ((push && !full) || (pop && !empty) || (psel && penable))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("%0t: timeout, nothing accepted for %0d cycles", $time, IDLE_LIMIT);
		$display("Some tests failed");
		$finish;
	end

endmodule

// ----- console_line_ring_writer.f -----
+incdir+design
design/clrw_pkg.sv
design/clrw_front.sv
design/clrw_back.sv
design/console_line_ring_writer.sv
design/clrw_checker.sv
verif/tb_console_line_ring_writer.sv
